@@ src/pfa_pkg.sv @@
// Shared constants, codes and state type for the prime field ALU.
package pfa_pkg;

  localparam int LIMB_W = 64;
  localparam int FE_W   = 256;

  // Field modulus q, R^2 mod q, and -q^-1 mod 2^64.
  localparam logic [FE_W-1:0] FQ = {
    64'd8353516859464449352, 64'd3691218898639771653,
    64'd6034159408538082302, 64'd18446744069414584321};
  localparam logic [FE_W-1:0] RSQ = {
    64'd524908885293268753, 64'd419701826671360399,
    64'd3129137299524312099, 64'd14526898881837571181};
  localparam logic [LIMB_W-1:0] QNEGINV = 64'd18446744069414584319;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_SUB    = 3'd1,
    MODE_NEG    = 3'd2,
    MODE_MUL    = 3'd3,
    MODE_INV    = 3'd4,
    MODE_TOMONT = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDSUB,
    S_REDQ,
    S_FIXQ,
    S_MUL,
    S_INV_RED,
    S_INV_ZCHK,
    S_HALF_V,
    S_HALF_U,
    S_ISUB,
    S_IFSUB,
    S_IFIX,
    S_DONE
  } state_t;

endpackage

@@ src/pfa_req_if.sv @@
// Request channel: mode and two four-limb operands.
interface pfa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] a_limb0;
  logic [63:0] a_limb1;
  logic [63:0] a_limb2;
  logic [63:0] a_limb3;
  logic [63:0] b_limb0;
  logic [63:0] b_limb1;
  logic [63:0] b_limb2;
  logic [63:0] b_limb3;

  modport source (output valid, mode, a_limb0, a_limb1, a_limb2, a_limb3,
                  b_limb0, b_limb1, b_limb2, b_limb3, input ready);
  modport sink (input valid, mode, a_limb0, a_limb1, a_limb2, a_limb3,
                b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

@@ src/pfa_rsp_if.sv @@
// Response channel: four-limb result and zero-inverse flag.
interface pfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] r_limb0;
  logic [63:0] r_limb1;
  logic [63:0] r_limb2;
  logic [63:0] r_limb3;
  logic        zero_inverse;

  modport source (output valid, r_limb0, r_limb1, r_limb2, r_limb3, zero_inverse,
                  input ready);
  modport sink (input valid, r_limb0, r_limb1, r_limb2, r_limb3, zero_inverse,
                output ready);
endinterface

@@ src/prime_field_alu_256.sv @@
// Prime field ALU top level: sequencer, shared 256-bit adder, 32x32 multiplier.
//
// req carries one beat per operation: mode, operand a and operand b (four
// 64-bit limbs each). rsp returns one beat per request: the result limbs and
// zero_inverse. req.ready is high only while the unit is idle; one request is
// worked at a time. Steps from accepted beat to result registered:
//   add / subtract / negate: add or subtract, reduction by q, result register
//   Montgomery multiply, to Montgomery form: 4 limbs x 9 limb products
//     (the 32x32 multiplier takes four passes per product), then the
//     final reduction and the result register
//   inverse: setup (two reductions of a by q, zero check), then halvings
//     of v or u and subtract rounds (odd checks on v and u, subtract, field
//     subtract, fix-up), then the result register; data dependent (the
//     single 256-bit adder sets the pace); a zero operand ends after the zero check
//   unused modes: no work, zero result
// The result waits in an output register; the unit takes the next request
// while that result is still pending, but holds a new result back until the
// pending one is taken. If rsp stalls, the unit stalls after that.
// rst (synchronous) returns the sequencer to idle and drops rsp.valid.
module prime_field_alu_256 (
  input  logic       clk,
  input  logic       rst,
  pfa_req_if.sink    req,
  pfa_rsp_if.source  rsp
);
  import pfa_pkg::*;

  state_t state, state_next;

  mode_t            mode;
  logic [FE_W-1:0]  x, y, w, u, v, s, r;
  logic             bflag, sel, zflag;
  logic             red_cnt;

  // multiply sequencer
  logic [1:0]        mi;
  logic [3:0]        mk;
  logic [2:0]        ms;
  logic [127:0]      acc;
  logic [63:0]       prod;
  logic [63:0]       c0, c1, c2, m;

  logic              ovalid;
  logic [FE_W-1:0]   rres;
  logic              rzero;

  // shared adder
  logic [FE_W-1:0]   add_x, add_y;
  logic              add_sub;
  logic [FE_W:0]     add_res;

  logic              v_ge_u;
  logic              u_one, v_one, u_zero, v_zero;
  logic [FE_W-1:0]   tgt, fixed, r_fin, s_fin;

  logic [63:0]       op_a, op_b, op_c, op_d, xi;
  logic [31:0]       pa, pb;
  logic [127:0]      pshift, acc_sum;
  logic              out_free;

  assign add_res = {1'b0, add_x} + {1'b0, add_y ^ {FE_W{add_sub}}} + {{FE_W{1'b0}}, add_sub};

  assign v_ge_u = (v >= u);
  assign u_one  = (u == {{(FE_W-1){1'b0}}, 1'b1});
  assign v_one  = (v == {{(FE_W-1){1'b0}}, 1'b1});
  assign u_zero = (u == '0);
  assign v_zero = (v == '0);
  assign tgt    = sel ? s : r;
  assign fixed  = bflag ? add_res[FE_W-1:0] : tgt;
  assign r_fin  = sel ? r : fixed;
  assign s_fin  = sel ? fixed : s;

  assign out_free = !ovalid || rsp.ready;

  // adder operand selection
  always_comb begin
    add_x   = x;
    add_y   = y;
    add_sub = 1'b0;
    case (state)
      S_ADDSUB: begin
        add_sub = (mode != MODE_ADD);
      end
      S_REDQ: begin
        add_x = w; add_y = FQ; add_sub = 1'b1;
      end
      S_FIXQ: begin
        add_x = w; add_y = FQ;
      end
      S_INV_RED: begin
        add_x = v; add_y = FQ; add_sub = 1'b1;
      end
      S_HALF_V: begin
        add_x = s; add_y = FQ;
      end
      S_HALF_U: begin
        add_x = r; add_y = FQ;
      end
      S_ISUB: begin
        add_x = v_ge_u ? v : u; add_y = v_ge_u ? u : v; add_sub = 1'b1;
      end
      S_IFSUB: begin
        add_x = sel ? s : r; add_y = sel ? r : s; add_sub = 1'b1;
      end
      S_IFIX: begin
        add_x = tgt; add_y = FQ;
      end
      default: begin
      end
    endcase
  end

  // limb product operands, per CIOS step
  assign xi = x[mi*64 +: 64];
  always_comb begin
    op_a = xi; op_b = y[63:0]; op_c = w[63:0]; op_d = '0;
    case (mk)
      4'd0: begin op_a = xi; op_b = y[63:0];    op_c = w[63:0];    op_d = '0; end
      4'd1: begin op_a = c0; op_b = QNEGINV;    op_c = '0;         op_d = '0; end
      4'd2: begin op_a = m;  op_b = FQ[63:0];   op_c = c0;         op_d = '0; end
      4'd3: begin op_a = xi; op_b = y[127:64];  op_c = c1;         op_d = w[127:64]; end
      4'd4: begin op_a = m;  op_b = FQ[127:64]; op_c = c2;         op_d = c0; end
      4'd5: begin op_a = xi; op_b = y[191:128]; op_c = c1;         op_d = w[191:128]; end
      4'd6: begin op_a = m;  op_b = FQ[191:128]; op_c = c2;        op_d = c0; end
      4'd7: begin op_a = xi; op_b = y[255:192]; op_c = c1;         op_d = w[255:192]; end
      4'd8: begin op_a = m;  op_b = FQ[255:192]; op_c = c0;        op_d = c2; end
      default: begin end
    endcase
  end

  assign pa = ms[0] ? op_a[63:32] : op_a[31:0];
  assign pb = ms[1] ? op_b[63:32] : op_b[31:0];

  // partial product from pass ms-1: pass 0 at bit 0, passes 1 and 2 at 32, pass 3 at 64
  always_comb begin
    case (ms)
      3'd1:    pshift = {64'd0, prod};
      3'd4:    pshift = {prod, 64'd0};
      default: pshift = {32'd0, prod, 32'd0};
    endcase
  end
  assign acc_sum = acc + pshift;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.mode)
            MODE_ADD, MODE_SUB, MODE_NEG: state_next = S_ADDSUB;
            MODE_MUL, MODE_TOMONT:        state_next = S_MUL;
            MODE_INV:                     state_next = S_INV_RED;
            default:                      state_next = S_DONE;
          endcase
        end
      end
      S_ADDSUB:   state_next = (mode == MODE_ADD) ? S_REDQ : S_FIXQ;
      S_REDQ:     state_next = S_DONE;
      S_FIXQ:     state_next = S_DONE;
      S_MUL: begin
        if (ms == 3'd4 && mk == 4'd8 && mi == 2'd3) state_next = S_REDQ;
      end
      S_INV_RED:  if (red_cnt) state_next = S_INV_ZCHK;
      S_INV_ZCHK: state_next = v_zero ? S_DONE : S_HALF_V;
      S_HALF_V:   if (v[0]) state_next = S_HALF_U;
      S_HALF_U:   if (u[0]) state_next = S_ISUB;
      S_ISUB:     state_next = S_IFSUB;
      S_IFSUB:    state_next = S_IFIX;
      S_IFIX: begin
        if (u_one || v_one || u_zero || v_zero) state_next = S_DONE;
        else state_next = S_HALF_V;
      end
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready        = (state == S_IDLE);
    rsp.valid        = ovalid;
    rsp.r_limb0      = rres[63:0];
    rsp.r_limb1      = rres[127:64];
    rsp.r_limb2      = rres[191:128];
    rsp.r_limb3      = rres[255:192];
    rsp.zero_inverse = rzero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) ovalid <= 1'b1;
      else if (rsp.ready) ovalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          mode    <= mode_t'(req.mode);
          zflag   <= 1'b0;
          w       <= '0;
          mi      <= '0;
          mk      <= '0;
          ms      <= '0;
          red_cnt <= 1'b0;
          v       <= {req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
          if (req.mode == MODE_NEG) begin
            x <= '0;
            y <= {req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
          end else begin
            x <= {req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
            if (req.mode == MODE_TOMONT) y <= RSQ;
            else y <= {req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0};
          end
        end
      end
      S_ADDSUB: begin
        w     <= add_res[FE_W-1:0];
        bflag <= !add_res[FE_W];
      end
      S_REDQ: begin
        if (add_res[FE_W]) w <= add_res[FE_W-1:0];
      end
      S_FIXQ: begin
        if (bflag) w <= add_res[FE_W-1:0];
      end
      S_MUL: begin
        if (ms != 3'd4) prod <= pa * pb;
        if (ms == 3'd0) acc <= {64'd0, op_c} + {64'd0, op_d};
        else acc <= acc_sum;
        if (ms == 3'd4) begin
          ms <= '0;
          case (mk)
            4'd0, 4'd3, 4'd5, 4'd7: begin
              c1 <= acc_sum[127:64]; c0 <= acc_sum[63:0];
            end
            4'd1: m  <= acc_sum[63:0];
            4'd2: c2 <= acc_sum[127:64];
            4'd4: begin c2 <= acc_sum[127:64]; w[63:0]    <= acc_sum[63:0]; end
            4'd6: begin c2 <= acc_sum[127:64]; w[127:64]  <= acc_sum[63:0]; end
            4'd8: begin
              w[255:192] <= acc_sum[127:64] + c1;
              w[191:128] <= acc_sum[63:0];
            end
            default: begin end
          endcase
          if (mk == 4'd8) begin
            mk <= '0;
            mi <= mi + 2'd1;
          end else begin
            mk <= mk + 4'd1;
          end
        end else begin
          ms <= ms + 3'd1;
        end
      end
      S_INV_RED: begin
        red_cnt <= 1'b1;
        if (add_res[FE_W]) v <= add_res[FE_W-1:0];
      end
      S_INV_ZCHK: begin
        zflag <= v_zero;
        u     <= FQ;
        s     <= RSQ;
        r     <= '0;
      end
      // carry out of s + q is dropped before the shift
      S_HALF_V: begin
        if (!v[0]) begin
          v <= {1'b0, v[FE_W-1:1]};
          s <= s[0] ? {1'b0, add_res[FE_W-1:1]} : {1'b0, s[FE_W-1:1]};
        end
      end
      S_HALF_U: begin
        if (!u[0]) begin
          u <= {1'b0, u[FE_W-1:1]};
          r <= r[0] ? {1'b0, add_res[FE_W-1:1]} : {1'b0, r[FE_W-1:1]};
        end
      end
      S_ISUB: begin
        sel <= v_ge_u;
        if (v_ge_u) v <= add_res[FE_W-1:0];
        else u <= add_res[FE_W-1:0];
      end
      S_IFSUB: begin
        bflag <= !add_res[FE_W];
        if (sel) s <= add_res[FE_W-1:0];
        else r <= add_res[FE_W-1:0];
      end
      S_IFIX: begin
        s <= s_fin;
        r <= r_fin;
        if (u_one) w <= r_fin;
        else if (v_one) w <= s_fin;
      end
      S_DONE: begin
        if (out_free) begin
          rres  <= w;
          rzero <= zflag;
        end
      end
      default: begin end
    endcase
  end

endmodule
